### rtl/cholesky_positive_definite_check_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positive definiteness checker
// Same-cycle and next-cycle implication checks, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CHOLESKY_POSITIVE_DEFINITE_CHECK_ASSERT_SVH
`define CHOLESKY_POSITIVE_DEFINITE_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
`define CPDC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed in the same cycle");
`define CPDC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed in the next cycle");
`else
`define CPDC_ASSERT_IMPL(name, ante, cons)
`define CPDC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### rtl/chol_pkg.sv
// ----------------------------------------------------------------------------
// chol_pkg
// Shared types and constants of the positive definiteness checker.
// ----------------------------------------------------------------------------
package chol_pkg;

  localparam int DIM_W  = 5;
  localparam int TOL_W  = 31;
  localparam int ADDR_W = 3;

  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_NOT_SYMMETRIC = 2'd1;
  localparam logic [1:0] STATUS_BAD_PIVOT     = 2'd2;
  localparam logic [1:0] STATUS_SIZE_ERROR    = 2'd3;

  localparam logic REG_DIMENSION = 1'b0;
  localparam logic REG_TOLERANCE = 1'b1;

  typedef struct packed {
    logic signed [31:0] matrix_element;
    logic               last_element;
  } chol_item_t;

  typedef struct packed {
    logic       positive_definite;
    logic [1:0] status_code;
    logic [3:0] failing_pivot;
  } chol_result_t;

  typedef struct packed {
    logic       accept;
    logic       rd_sym_a;
    logic       rd_sym_b;
    logic       sym_sq;
    logic       sym_add;
    logic       fac_init;
    logic       rd_m;
    logic       acc_init;
    logic       rd_la;
    logic       rd_lb;
    logic       mul;
    logic       sub;
    logic       rd_diag;
    logic       div_start;
    logic       wr_off;
    logic       sqrt_start;
    logic       wr_diag;
    logic       set_res;
    logic [1:0] res_code;
  } chol_cmd_t;

  typedef struct packed {
    logic cfg_bad;
    logic sym_last;
    logic sym_ok;
    logic j_zero;
    logic j_eq_i;
    logic k_last;
    logic acc_pos;
    logic unit_done;
    logic i_last;
  } chol_stat_t;

endpackage

### rtl/chol_iter.sv
// ----------------------------------------------------------------------------
// chol_iter
// Shared iterative unit: 64-by-32 division one quotient bit per cycle, and
// 64-bit integer square root one result bit per cycle.
// ----------------------------------------------------------------------------
module chol_iter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               div_start_i,
  input  logic               sqrt_start_i,
  input  logic signed [63:0] operand_i,
  input  logic signed [31:0] divisor_i,
  output logic signed [31:0] result_o,
  output logic               done_o
);
  import chol_pkg::*;

  logic        run_q, sqrt_q, neg_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] x_q, y_q, z_q;
  logic [31:0] rem_q, d_q;
  logic [31:0] res_q;

  logic [63:0] s_sum;
  logic        s_ge;
  logic [32:0] t_rem;
  logic        t_ge;

  assign s_sum = y_q + z_q;
  assign s_ge  = (x_q >= s_sum);
  assign t_rem = {rem_q, x_q[63]};
  assign t_ge  = (t_rem >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !div_start_i && !sqrt_start_i && run_q && (cnt_q == 7'd0);
      if (div_start_i) begin
        run_q <= 1'b1;
        cnt_q <= 7'd64;
      end else if (sqrt_start_i) begin
        run_q <= 1'b1;
        cnt_q <= 7'd32;
      end else if (run_q) begin
        if (cnt_q != 7'd0) begin
          cnt_q <= cnt_q - 7'd1;
        end else begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start_i) begin
      sqrt_q <= 1'b0;
      neg_q  <= operand_i[63];
      x_q    <= operand_i[63] ? (64'd0 - operand_i) : operand_i;
      rem_q  <= '0;
      d_q    <= divisor_i;
    end else if (sqrt_start_i) begin
      sqrt_q <= 1'b1;
      x_q    <= operand_i;
      y_q    <= '0;
      z_q    <= 64'd1 << 62;
    end else if (run_q) begin
      if (cnt_q != 7'd0) begin
        if (sqrt_q) begin
          x_q <= s_ge ? (x_q - s_sum) : x_q;
          y_q <= s_ge ? ((y_q >> 1) + z_q) : (y_q >> 1);
          z_q <= z_q >> 2;
        end else begin
          rem_q <= t_ge ? 32'(t_rem - {1'b0, d_q}) : t_rem[31:0];
          x_q   <= {x_q[62:0], t_ge};
        end
      end else if (sqrt_q) begin
        res_q <= (y_q[63:31] != '0) ? 32'h7FFF_FFFF : y_q[31:0];
      end else if (x_q[63:31] != '0) begin
        res_q <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        res_q <= neg_q ? (32'd0 - x_q[31:0]) : x_q[31:0];
      end
    end
  end

  assign result_o = res_q;
  assign done_o   = done_q;

endmodule

### rtl/chol_dp.sv
// ----------------------------------------------------------------------------
// chol_dp
// Datapath: matrix and factor memories, loop indices, symmetry accumulator,
// Cholesky accumulator and the verdict register.
// ----------------------------------------------------------------------------
module chol_dp #(
  parameter int MAX_DIMENSION = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  chol_pkg::chol_cmd_t      cmd_i,
  input  chol_pkg::chol_item_t     item_i,
  input  logic [chol_pkg::DIM_W-1:0] dimension_i,
  input  logic [chol_pkg::TOL_W-1:0] tolerance_i,
  output chol_pkg::chol_stat_t     stat_o,
  output chol_pkg::chol_result_t   result_o,
  output logic                     done_o
);
  import chol_pkg::*;

  localparam int DEPTH = MAX_DIMENSION * MAX_DIMENSION;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 2);
  localparam int NW    = $clog2(MAX_DIMENSION + 1);

  logic signed [31:0] m_mem [DEPTH];
  logic signed [31:0] l_mem [DEPTH];

  logic [CW-1:0]      count_q;
  logic [NW-1:0]      n_q, i_q, j_q, k_q;
  logic [61:0]        tolsq_q;
  logic [63:0]        sum_q, sq_q;
  logic signed [31:0] a_q, m_rd_q, l_rd_q;
  logic signed [63:0] acc_q, prod_q;
  chol_result_t       result_q;
  logic               done_q;

  logic               room;
  logic [CW-1:0]      count_inc;
  logic [10:0]        nsq;
  logic [AW-1:0]      m_ij, m_ji, l_ik, l_jk, l_jj, l_ij, m_raddr, l_raddr;
  logic [32:0]        diff, mag;
  logic [61:0]        sqp;
  logic [64:0]        sum_ext;
  logic [64:0]        sdiff;
  logic signed [63:0] acc_sub;
  logic signed [31:0] unit_res;
  logic               unit_done;

  assign room      = (count_q < CW'(DEPTH));
  assign count_inc = room ? (count_q + CW'(1)) : CW'(DEPTH + 1);
  assign nsq       = 11'(dimension_i) * 11'(dimension_i);

  assign m_ij = AW'(32'(i_q) * 32'(n_q) + 32'(j_q));
  assign m_ji = AW'(32'(j_q) * 32'(n_q) + 32'(i_q));
  assign l_ik = AW'(32'(i_q) * MAX_DIMENSION + 32'(k_q));
  assign l_jk = AW'(32'(j_q) * MAX_DIMENSION + 32'(k_q));
  assign l_jj = AW'(32'(j_q) * MAX_DIMENSION + 32'(j_q));
  assign l_ij = AW'(32'(i_q) * MAX_DIMENSION + 32'(j_q));

  assign m_raddr = cmd_i.rd_sym_b ? m_ji : m_ij;
  assign l_raddr = cmd_i.rd_la ? l_ik : (cmd_i.rd_lb ? l_jk : l_jj);

  // Squared element difference, saturated when the magnitude reaches 2^31.
  assign diff    = {a_q[31], a_q} - {m_rd_q[31], m_rd_q};
  assign mag     = diff[32] ? (33'd0 - diff) : diff;
  assign sqp     = 62'(mag[30:0]) * 62'(mag[30:0]);
  assign sum_ext = {1'b0, sum_q} + {1'b0, sq_q};

  assign sdiff   = {acc_q[63], acc_q} - {prod_q[63], prod_q};
  assign acc_sub = (sdiff[64] != sdiff[63]) ?
                   (sdiff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sdiff[63:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && room) begin
      m_mem[count_q[AW-1:0]] <= item_i.matrix_element;
    end
    m_rd_q <= m_mem[m_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_off || cmd_i.wr_diag) begin
      l_mem[l_ij] <= unit_res;
    end
    l_rd_q <= l_mem[l_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.set_res;
      if (cmd_i.accept) begin
        count_q <= item_i.last_element ? '0 : count_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && item_i.last_element) begin
      n_q     <= NW'(dimension_i);
      tolsq_q <= 62'(tolerance_i) * 62'(tolerance_i);
      sum_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end
    if (cmd_i.rd_sym_b) a_q <= m_rd_q;
    if (cmd_i.rd_lb)    a_q <= l_rd_q;
    if (cmd_i.sym_sq)   sq_q <= (mag[32:31] != 2'b00) ? '1 : 64'(sqp);
    if (cmd_i.sym_add) begin
      sum_q <= sum_ext[64] ? '1 : sum_ext[63:0];
      if (32'(j_q) + 1 == 32'(n_q)) begin
        j_q <= '0;
        i_q <= i_q + NW'(1);
      end else begin
        j_q <= j_q + NW'(1);
      end
    end
    if (cmd_i.fac_init) begin
      i_q <= '0;
      j_q <= '0;
    end
    if (cmd_i.acc_init) begin
      acc_q <= {{32{m_rd_q[31]}}, m_rd_q} << FRACTION_BITS;
      k_q   <= '0;
    end
    if (cmd_i.mul) prod_q <= 64'(a_q) * 64'(l_rd_q);
    if (cmd_i.sub) begin
      acc_q <= acc_sub;
      k_q   <= k_q + NW'(1);
    end
    if (cmd_i.wr_off) j_q <= j_q + NW'(1);
    if (cmd_i.wr_diag) begin
      i_q <= i_q + NW'(1);
      j_q <= '0;
    end
    if (cmd_i.set_res) begin
      result_q.positive_definite <= (cmd_i.res_code == STATUS_OK);
      result_q.status_code       <= cmd_i.res_code;
      result_q.failing_pivot     <= (cmd_i.res_code == STATUS_BAD_PIVOT) ? 4'(i_q) : 4'd0;
    end
  end

  chol_iter u_iter (
    .clk_i,
    .rst_ni,
    .div_start_i  (cmd_i.div_start),
    .sqrt_start_i (cmd_i.sqrt_start),
    .operand_i    (acc_q),
    .divisor_i    (l_rd_q),
    .result_o     (unit_res),
    .done_o       (unit_done)
  );

  assign stat_o.cfg_bad   = (dimension_i == '0) || (32'(dimension_i) > MAX_DIMENSION) ||
                            (32'(count_inc) != 32'(nsq));
  assign stat_o.i_last    = (32'(i_q) + 1 == 32'(n_q));
  assign stat_o.sym_last  = stat_o.i_last && (32'(j_q) + 1 == 32'(n_q));
  assign stat_o.sym_ok    = (sum_q <= 64'(tolsq_q));
  assign stat_o.j_zero    = (j_q == '0);
  assign stat_o.j_eq_i    = (j_q == i_q);
  assign stat_o.k_last    = (32'(k_q) + 1 == 32'(j_q));
  assign stat_o.acc_pos   = !acc_q[63] && (acc_q != '0);
  assign stat_o.unit_done = unit_done;

  assign result_o = result_q;
  assign done_o   = done_q;

endmodule

### rtl/chol_ctrl.sv
// ----------------------------------------------------------------------------
// chol_ctrl
// Sequencer: loading, symmetry pass and row-wise factorization.
// ----------------------------------------------------------------------------
module chol_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 last_i,
  input  chol_pkg::chol_stat_t stat_i,
  output chol_pkg::chol_cmd_t  cmd_o,
  output logic                 busy_o
);
  import chol_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_SYM_RA = 16'h0002,
    S_SYM_RB = 16'h0004,
    S_SYM_SQ = 16'h0008,
    S_SYM_AD = 16'h0010,
    S_SYM_CM = 16'h0020,
    S_F_RDM  = 16'h0040,
    S_F_INIT = 16'h0080,
    S_F_RDA  = 16'h0100,
    S_F_RDB  = 16'h0200,
    S_F_MUL  = 16'h0400,
    S_F_SUB  = 16'h0800,
    S_F_RDD  = 16'h1000,
    S_F_DIV  = 16'h2000,
    S_F_TEST = 16'h4000,
    S_F_WAIT = 16'h8000
  } chol_state_e;

  chol_state_e state_q, state_d;
  logic        diag_q, diag_d;

  always_comb begin
    state_d = state_q;
    diag_d  = diag_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (last_i) begin
            if (stat_i.cfg_bad) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = STATUS_SIZE_ERROR;
            end else begin
              state_d = S_SYM_RA;
            end
          end
        end
      end
      S_SYM_RA: begin
        cmd_o.rd_sym_a = 1'b1;
        state_d = S_SYM_RB;
      end
      S_SYM_RB: begin
        cmd_o.rd_sym_b = 1'b1;
        state_d = S_SYM_SQ;
      end
      S_SYM_SQ: begin
        cmd_o.sym_sq = 1'b1;
        state_d = S_SYM_AD;
      end
      S_SYM_AD: begin
        cmd_o.sym_add = 1'b1;
        state_d = stat_i.sym_last ? S_SYM_CM : S_SYM_RA;
      end
      S_SYM_CM: begin
        if (!stat_i.sym_ok) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STATUS_NOT_SYMMETRIC;
          state_d = S_IDLE;
        end else begin
          cmd_o.fac_init = 1'b1;
          state_d = S_F_RDM;
        end
      end
      S_F_RDM: begin
        cmd_o.rd_m = 1'b1;
        state_d = S_F_INIT;
      end
      S_F_INIT: begin
        cmd_o.acc_init = 1'b1;
        if (!stat_i.j_zero) begin
          state_d = S_F_RDA;
        end else begin
          state_d = stat_i.j_eq_i ? S_F_TEST : S_F_RDD;
        end
      end
      S_F_RDA: begin
        cmd_o.rd_la = 1'b1;
        state_d = S_F_RDB;
      end
      S_F_RDB: begin
        cmd_o.rd_lb = 1'b1;
        state_d = S_F_MUL;
      end
      S_F_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_F_SUB;
      end
      S_F_SUB: begin
        cmd_o.sub = 1'b1;
        if (!stat_i.k_last) begin
          state_d = S_F_RDA;
        end else begin
          state_d = stat_i.j_eq_i ? S_F_TEST : S_F_RDD;
        end
      end
      S_F_RDD: begin
        cmd_o.rd_diag = 1'b1;
        state_d = S_F_DIV;
      end
      S_F_DIV: begin
        cmd_o.div_start = 1'b1;
        diag_d  = 1'b0;
        state_d = S_F_WAIT;
      end
      S_F_TEST: begin
        if (!stat_i.acc_pos) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STATUS_BAD_PIVOT;
          state_d = S_IDLE;
        end else begin
          cmd_o.sqrt_start = 1'b1;
          diag_d  = 1'b1;
          state_d = S_F_WAIT;
        end
      end
      S_F_WAIT: begin
        if (stat_i.unit_done) begin
          if (!diag_q) begin
            cmd_o.wr_off = 1'b1;
            state_d = S_F_RDM;
          end else begin
            cmd_o.wr_diag = 1'b1;
            if (stat_i.i_last) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = STATUS_OK;
              state_d = S_IDLE;
            end else begin
              state_d = S_F_RDM;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      diag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      diag_q  <= diag_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### rtl/cholesky_positive_definite_check.sv
// Loading: a word is taken while busy is low; a bad element count gives its verdict in the next cycle.
// Otherwise the verdict follows a symmetry pass, then the factorization row by row, which uses
// the one-bit-per-cycle divide and root unit.
// Throughput: one matrix at a time; busy stays high until the verdict is out.
// Reset: asynchronous and active low; the block returns to loading with an empty count,
// dimension 16 and tolerance 66. The stores need no clearing. Results cannot be stalled.
// ----------------------------------------------------------------------------
// cholesky_positive_definite_check
// Loads a square Q16.16 matrix word by word, checks symmetry against a
// Frobenius tolerance and runs a fixed-point Cholesky factorization.
// ----------------------------------------------------------------------------
`include "cholesky_positive_definite_check_assert.svh"

module cholesky_positive_definite_check #(
  parameter int MAX_DIMENSION = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command-style item port: a word is taken when start is high and busy is low.
  input  logic                        start,
  output logic                        busy,
  input  chol_pkg::chol_item_t        item_i,
  // Verdict: valid for exactly the one cycle in which done_o is high.
  output logic                        done_o,
  output chol_pkg::chol_result_t      result_o,
  // Register port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [chol_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import chol_pkg::*;

  logic [DIM_W-1:0] dim_q;
  logic [TOL_W-1:0] tol_q;
  logic             reg_wr;
  chol_cmd_t        cmd;
  chol_stat_t       stat;

  // The register index is the word address; the byte offset bits are ignored.
  // Writes are expected only while the block is idle.
  assign reg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_W'(16);
      tol_q <= TOL_W'(66);
    end else if (reg_wr) begin
      unique case (paddr[2])
        REG_DIMENSION: dim_q <= pwdata[DIM_W-1:0];
        REG_TOLERANCE: tol_q <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DIMENSION: prdata = 32'(dim_q);
      REG_TOLERANCE: prdata = 32'(tol_q);
      default:       prdata = '0;
    endcase
  end

  // The sequencer drives the datapath with one-cycle commands and reads back
  // loop and comparison flags; the datapath owns both memories.
  chol_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i (start),
    .last_i  (item_i.last_element),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  chol_dp #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .item_i      (item_i),
    .dimension_i (dim_q),
    .tolerance_i (tol_q),
    .stat_o      (stat),
    .result_o    (result_o),
    .done_o      (done_o)
  );

  // A verdict only appears once the sequencer is back in its loading state.
  `CPDC_ASSERT_IMPL(a_done_not_busy, done_o, !busy)
  // A word that is not the last one never starts a computation or a verdict.
  `CPDC_ASSERT_NEXT(a_plain_word_quiet, start && !busy && !item_i.last_element, !busy && !done_o)
  // The positive flag agrees with the status code.
  `CPDC_ASSERT_IMPL(a_flag_matches_code, done_o, result_o.positive_definite == (result_o.status_code == STATUS_OK))
  // Only a failing pivot reports a row.
  `CPDC_ASSERT_IMPL(a_pivot_only_on_fail, done_o && (result_o.status_code != STATUS_BAD_PIVOT), result_o.failing_pivot == 4'd0)

endmodule

### sim/tb_cholesky_positive_definite_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cholesky_positive_definite_check
// Self-checking bench: streams matrices word by word, predicts each verdict
// with a bit-exact fixed-point Cholesky model and compares every field.
// ----------------------------------------------------------------------------
module tb_cholesky_positive_definite_check;
  import chol_pkg::*;

  localparam int  STORE_N   = 256;
  localparam int  NUM_WORDS = 1500;
  localparam longint CYCLE_LIMIT = 3000000;

  // Mirror of the block: register copies, the matrix and factor stores, and the
  // queue of verdicts still to come.
  class pd_scoreboard;
    logic signed [31:0] mat[STORE_N];
    logic signed [31:0] fac[STORE_N];
    int unsigned  word_cnt;
    bit [4:0]     dim;
    bit [30:0]    tol;
    chol_result_t pending[$];
    int           mismatches;
    int           failures;

    function new();
      word_cnt = 0;
      dim = 5'd16;
      tol = 31'd66;
    endfunction

    function void write_reg(logic idx, logic [31:0] v);
      if (idx == REG_DIMENSION) dim = v[4:0];
      else tol = v[30:0];
    endfunction

    function longint sat_sub(longint a, longint b);
      longint lo, hi;
      lo = 64'sh8000_0000_0000_0000;
      hi = 64'sh7fff_ffff_ffff_ffff;
      if (b > 0 && a < lo + b) return lo;
      if (b < 0 && a > hi + b) return hi;
      return a - b;
    endfunction

    function logic signed [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Squared Frobenius norm of M - M^T against the squared tolerance.
    function bit is_symmetric(int n);
      bit [63:0] sum, sq, m, lim;
      longint d;
      sum = 0;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          d = longint'(mat[i*n+j]) - longint'(mat[j*n+i]);
          m = (d < 0) ? -d : d;
          sq = (m >= 64'h8000_0000) ? '1 : m * m;
          sum = (sum > ~sq) ? '1 : sum + sq;
        end
      lim = 64'(tol) * 64'(tol);
      return sum <= lim;
    endfunction

    // Row-wise factorization; returns the first row with a non-positive pivot, or n.
    function int first_bad_row(int n);
      longint acc, e;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < i; j++) begin
          acc = longint'(mat[i*n+j]) <<< 16;
          for (int k = 0; k < j; k++)
            acc = sat_sub(acc, longint'(fac[i*16+k]) * longint'(fac[j*16+k]));
          fac[i*16+j] = sat32(acc / longint'(fac[j*16+j]));
        end
        acc = longint'(mat[i*n+i]) <<< 16;
        for (int j = 0; j < i; j++) begin
          e = longint'(fac[i*16+j]);
          acc = sat_sub(acc, e * e);
        end
        if (acc <= 0) return i;
        fac[i*16+i] = sat32(longint'(int_sqrt(acc)));
      end
      return n;
    endfunction

    function void note_word(chol_item_t w);
      chol_result_t r;
      int n, cnt, row;
      if (word_cnt < STORE_N) begin
        mat[word_cnt] = w.matrix_element;
        word_cnt++;
      end else begin
        word_cnt = STORE_N + 1;
      end
      if (!w.last_element) return;
      n = dim;
      cnt = word_cnt;
      word_cnt = 0;
      r = '0;
      if (n == 0 || n > 16 || cnt != n * n) begin
        r.status_code = STATUS_SIZE_ERROR;
      end else if (!is_symmetric(n)) begin
        r.status_code = STATUS_NOT_SYMMETRIC;
      end else begin
        row = first_bad_row(n);
        if (row < n) begin
          r.status_code = STATUS_BAD_PIVOT;
          r.failing_pivot = row[3:0];
        end else begin
          r.status_code = STATUS_OK;
          r.positive_definite = 1'b1;
        end
      end
      pending = {pending, r};
    endfunction

    function void check_verdict(chol_result_t got);
      chol_result_t want;
      if (pending.size() == 0) begin
        failures++;
        if (mismatches < 10) $display("unexpected verdict %p", got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        failures++;
        if (mismatches < 10) $display("verdict mismatch: expected %p, got %p", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  chol_item_t   item_i = '0;
  logic         done_o;
  chol_result_t result_o;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  pd_scoreboard sb = new();
  logic signed [31:0] words[$];   // words of the matrix about to be sent
  int  sent_words = 0;
  bit  no_gaps = 0;
  longint cycles = 0;

  cholesky_positive_definite_check dut (.*);

  always #1 clk_i = ~clk_i;

  // Every verdict is on the port for one cycle only, so it is taken at every edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_verdict(result_o);
  end

  // Watchdog: the slowest legal run is far below this.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[cholesky_positive_definite_check] ERROR");
      $finish;
    end
  end

  // Appends one word to the matrix about to be sent.
  task automatic queue_word(logic signed [31:0] v);
    words = {words, v};
  endtask

  // Sends one word. start stays high between back-to-back words; it only drops
  // when a gap is drawn, so it never gets two updates in one time step.
  task automatic send_word(logic signed [31:0] v, logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= '{matrix_element: v, last_element: last};
    do @(posedge clk_i); while (busy);
    sb.note_word('{matrix_element: v, last_element: last});
    sent_words++;
  endtask

  task automatic send_words();
    for (int i = 0; i < words.size(); i++) send_word(words[i], i == words.size() - 1);
    words.delete();
  endtask

  // Brings the block to rest: no word offered, every verdict in, busy low and a
  // short margin, since a word without the last mark yields nothing to wait for.
  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic idx, logic [31:0] v);
    go_idle();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Fills words with an n-by-n matrix of the given flavor.
  task automatic build_matrix(int n, int flavor);
    logic signed [31:0] m[STORE_N];
    longint rowsum;
    int k;
    for (int i = 0; i < n; i++)
      for (int j = 0; j <= i; j++) begin
        m[i*n+j] = (flavor == 1) ? 32'($urandom)
                                 : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        m[j*n+i] = m[i*n+j];
      end
    if (flavor != 1)
      for (int i = 0; i < n; i++) begin
        // Diagonal dominance makes the matrix positive definite.
        rowsum = 0;
        for (int j = 0; j < n; j++) if (j != i) rowsum += (m[i*n+j] < 0) ? -m[i*n+j] : m[i*n+j];
        m[i*n+i] = 32'(rowsum + $urandom_range(1, 1 << 20));
      end
    k = $urandom_range(0, n - 1);
    case (flavor)
      2: m[k*n + $urandom_range(0, n - 1)] += $signed($urandom_range(0, 400)) - 200;
      3: for (int i = 0; i < n * n; i++) m[i] = 32'($urandom);
      4: m[k*n+k] = -$signed($urandom_range(0, 1 << 20));
      default: ;
    endcase
    for (int i = 0; i < n * n; i++) queue_word(m[i]);
  endtask

  initial begin
    int n, cnt;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extreme single entries, size errors, saturating asymmetry.
    reg_write(REG_DIMENSION, 32'd1);
    send_word(32'sh7fff_ffff, 1'b1);
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sh0000_0000, 1'b1);
    reg_write(REG_DIMENSION, 32'd2);
    words = '{32'sd1, 32'sd2, 32'sd3};
    send_words();
    words = '{32'sh20000, 32'sh10000, 32'sh10000, 32'sh20000};
    send_words();
    // Differences of 2^31 and more saturate the norm.
    words = '{32'sd1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1};
    send_words();
    // Dimension changed partway through loading: the value at the mark counts.
    reg_write(REG_DIMENSION, 32'd3);
    send_word(32'sh10000, 1'b0);
    send_word(32'sd0, 1'b0);
    reg_write(REG_DIMENSION, 32'd2);
    send_word(32'sd0, 1'b0);
    send_word(32'sh10000, 1'b1);
    reg_write(REG_DIMENSION, 32'd0);
    send_word(32'sd5, 1'b1);
    reg_write(REG_DIMENSION, 32'hffff_ffff);
    send_word(32'sd5, 1'b1);
    reg_write(REG_TOLERANCE, 32'hffff_ffff);
    reg_write(REG_DIMENSION, 32'd16);
    // Overlong matrix: the count saturates past the store.
    no_gaps = 1;
    for (int i = 0; i < 259; i++) queue_word(32'($urandom));
    send_words();
    build_matrix(16, 0);
    send_words();
    no_gaps = 0;
    reg_write(REG_TOLERANCE, 32'd0);

    // Random part: mostly well-formed matrices of small size.
    while (sent_words < NUM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 9))
          0: reg_write(REG_DIMENSION, 32'($urandom_range(0, 31)));
          1: reg_write(REG_DIMENSION, 32'd16);
          2: reg_write(REG_TOLERANCE, 32'($urandom));
          3: reg_write(REG_TOLERANCE, 32'($urandom_range(0, 300)));
          4: reg_write(REG_TOLERANCE, 32'd0);
          5: reg_write(REG_TOLERANCE, 32'h7fff_ffff);
          default: reg_write(REG_DIMENSION, 32'($urandom_range(1, 5)));
        endcase
      end
      n = (sb.dim >= 1 && sb.dim <= 16) ? sb.dim : $urandom_range(1, 4);
      no_gaps = ($urandom_range(0, 3) == 0);
      build_matrix(n, $urandom_range(0, 5) < 2 ? 0 : $urandom_range(0, 4));
      if ($urandom_range(0, 7) == 0) begin
        // Wrong element count: drop or add a few words.
        cnt = n * n + $urandom_range(1, n + 1) * ($urandom_range(0, 1) ? 1 : -1);
        if (cnt < 1) cnt = n * n + 1;
        while (words.size() > cnt) void'(words.pop_back());
        while (words.size() < cnt) queue_word(32'($urandom));
      end
      send_words();
    end

    go_idle();
    repeat (50) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("[cholesky_positive_definite_check] OK");
    end else begin
      $display("[cholesky_positive_definite_check] ERROR");
    end
    $finish;
  end

endmodule
